[src/cbm_pkg.sv]
// Shared types, codes and constants of the cartridge bank mapper.
package cbm_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_CPU_WRITE = 2'd0;
	localparam logic [1:0] KIND_CPU_TICK  = 2'd1;
	localparam logic [1:0] KIND_PPU_CYCLE = 2'd2;

	// Write regions by CPU address bits 15:13.
	localparam logic [2:0] REGION_BANK   = 3'd4;
	localparam logic [2:0] REGION_MIRROR = 3'd5;
	localparam logic [2:0] REGION_IRQ    = 3'd6;

	// Bank data targets selected by command bits 3:0.
	localparam logic [3:0] SEL_CHR0 = 4'd0;
	localparam logic [3:0] SEL_CHR2 = 4'd1;
	localparam logic [3:0] SEL_CHR4 = 4'd2;
	localparam logic [3:0] SEL_CHR5 = 4'd3;
	localparam logic [3:0] SEL_CHR6 = 4'd4;
	localparam logic [3:0] SEL_CHR7 = 4'd5;
	localparam logic [3:0] SEL_PRG0 = 4'd6;
	localparam logic [3:0] SEL_PRG1 = 4'd7;
	localparam logic [3:0] SEL_CHR1 = 4'd8;
	localparam logic [3:0] SEL_CHR3 = 4'd9;
	localparam logic [3:0] SEL_PRG2 = 4'd15;

	// Command bits.
	localparam int CMD_CHR_INVERT = 7;
	localparam int CMD_PRG_SWAP   = 6;
	localparam int CMD_CHR_1K     = 5;

	// IRQ clock sources.
	localparam logic [3:0] A12_FILTER_CYCLES = 4'd8;
	localparam logic [2:0] CPU_PRESCALE      = 3'd4;

	localparam logic [7:0] PRG_LAST_BANK = 8'hFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] cpu_addr;
		logic [7:0]  write_data;
		logic [13:0] ppu_addr;
	} cbm_item_t;

	typedef struct packed {
		logic [7:0] prg_bank;
		logic [7:0] chr_bank;
		logic       mirror_horizontal;
		logic       irq;
	} cbm_result_t;

	// Bank registers as seen by the address lookup.
	typedef struct packed {
		logic [7:0]      command;
		logic [2:0][7:0] prg_regs;
		logic [7:0][7:0] chr_regs;
	} cbm_banks_t;

endpackage

[src/cbm_channels.sv]
// Valid/ready channel interfaces for mapper items and results.
interface cbm_item_if import cbm_pkg::*; ();
	logic      valid;
	logic      ready;
	cbm_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cbm_result_if import cbm_pkg::*; ();
	logic        valid;
	logic        ready;
	cbm_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/cbm_bank_lookup.sv]
// PRG and CHR bank lookup from the bank registers and the bus addresses.
module cbm_bank_lookup import cbm_pkg::*; (
	input  cbm_banks_t  banks,
	input  logic [15:0] cpu_addr,
	input  logic [13:0] ppu_addr,
	output logic [7:0]  prg_bank,
	output logic [7:0]  chr_bank
);

	logic [1:0] prg_slot;
	logic [2:0] chr_slot;
	logic [2:0] chr_idx;
	logic [1:0] pair_idx;

	// PRG: the top slot is fixed to the last bank; swap mode rotates the others.
	always_comb begin
		prg_slot = cpu_addr[14:13];
		if (!cpu_addr[15]) begin
			prg_bank = 8'd0;
		end else if (prg_slot == 2'd3) begin
			prg_bank = PRG_LAST_BANK;
		end else if (banks.command[CMD_PRG_SWAP]) begin
			case (prg_slot)
				2'd0:    prg_bank = banks.prg_regs[2];
				2'd1:    prg_bank = banks.prg_regs[0];
				default: prg_bank = banks.prg_regs[1];
			endcase
		end else begin
			prg_bank = banks.prg_regs[prg_slot];
		end
	end

	// CHR: inversion swaps the halves; in 2K mode the low half uses bank pairs.
	always_comb begin
		chr_slot = ppu_addr[12:10];
		chr_idx  = chr_slot ^ {banks.command[CMD_CHR_INVERT], 2'b00};
		pair_idx = {chr_idx[1], 1'b0};
		if (ppu_addr[13]) begin
			chr_bank = 8'd0;
		end else if (banks.command[CMD_CHR_1K] || chr_idx[2]) begin
			chr_bank = banks.chr_regs[chr_idx];
		end else begin
			chr_bank = {banks.chr_regs[{1'b0, pair_idx}][7:1], chr_slot[0]};
		end
	end

endmodule

[src/cartridge_bank_mapper_irq.sv]
// Cartridge bank mapper with scanline IRQ counter: top level.
// Takes one bus event (CPU write, CPU tick or PPU bus cycle) per transaction and
// returns one result per transaction: the PRG and CHR banks for the item's
// addresses, the mirroring and the IRQ line, all after the event has taken
// effect. One item is accepted per cycle while the output register is empty or
// its result is taken; the result is in the output register in the cycle after
// acceptance. State update and bank lookup form a single registered pass, and
// the output register takes a new result in the same cycle that the previous one
// is taken; a result-side stall holds the input only while the register is full.
module cartridge_bank_mapper_irq import cbm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cbm_item_if.sink     item,
	cbm_result_if.source result
);

	logic [7:0]      cmd_q;
	logic [2:0][7:0] prg_q;
	logic [7:0][7:0] chr_q;
	logic            mirror_q;
	logic            irq_en_q;
	logic [7:0]      cnt_q;
	logic [7:0]      latch_q;
	logic            cycle_mode_q;
	logic            reload_q;
	logic [3:0]      filt_q;
	logic            pend_q;
	logic [2:0]      presc_q;
	logic            irq_q;

	logic [7:0]      cmd_d;
	logic [2:0][7:0] prg_d;
	logic [7:0][7:0] chr_d;
	logic            mirror_d;
	logic            irq_en_d;
	logic [7:0]      cnt_d;
	logic [7:0]      latch_d;
	logic            cycle_mode_d;
	logic            reload_d;
	logic [3:0]      filt_d;
	logic            pend_d;
	logic [2:0]      presc_d;
	logic            irq_d;

	logic        out_valid_q;
	cbm_result_t out_q;
	logic        accept;
	cbm_item_t   it;
	cbm_banks_t  banks_d;
	logic [7:0]  prg_bank;
	logic [7:0]  chr_bank;
	logic [2:0]  presc_dec;
	logic [3:0]  filt_dec;

	assign it     = item.data;
	assign accept = item.valid && item.ready;

	// The output register frees up when its result is taken.
	assign item.ready   = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// Next state for the accepted event.
	always_comb begin
		cmd_d        = cmd_q;
		prg_d        = prg_q;
		chr_d        = chr_q;
		mirror_d     = mirror_q;
		irq_en_d     = irq_en_q;
		cnt_d        = cnt_q;
		latch_d      = latch_q;
		cycle_mode_d = cycle_mode_q;
		reload_d     = reload_q;
		filt_d       = filt_q;
		pend_d       = pend_q;
		presc_d      = presc_q;
		irq_d        = irq_q;
		presc_dec    = presc_q - 3'd1;
		filt_dec     = (filt_q != 4'd0) ? filt_q - 4'd1 : 4'd0;
		case (it.kind)
			KIND_CPU_WRITE: begin
				if (it.cpu_addr[15]) begin
					case (it.cpu_addr[15:13])
						REGION_BANK: begin
							if (!it.cpu_addr[0]) begin
								cmd_d = it.write_data;
							end else begin
								case (cmd_q[3:0])
									SEL_CHR0: chr_d[0] = it.write_data;
									SEL_CHR2: chr_d[2] = it.write_data;
									SEL_CHR4: chr_d[4] = it.write_data;
									SEL_CHR5: chr_d[5] = it.write_data;
									SEL_CHR6: chr_d[6] = it.write_data;
									SEL_CHR7: chr_d[7] = it.write_data;
									SEL_PRG0: prg_d[0] = it.write_data;
									SEL_PRG1: prg_d[1] = it.write_data;
									SEL_CHR1: chr_d[1] = it.write_data;
									SEL_CHR3: chr_d[3] = it.write_data;
									SEL_PRG2: prg_d[2] = it.write_data;
									default: ;
								endcase
							end
						end
						REGION_MIRROR: begin
							if (!it.cpu_addr[0]) begin
								mirror_d = it.write_data[0];
							end
						end
						REGION_IRQ: begin
							if (it.cpu_addr[0]) begin
								cycle_mode_d = it.write_data[0];
								reload_d     = 1'b1;
							end else begin
								latch_d = it.write_data;
							end
						end
						default: begin
							irq_en_d = it.cpu_addr[0];
							if (!it.cpu_addr[0]) begin
								irq_d = 1'b0;
							end
						end
					endcase
				end
			end
			KIND_CPU_TICK: begin
				// A pending counter clock takes effect on this tick.
				if (pend_q) begin
					if (cnt_q == 8'd0 || reload_q) begin
						cnt_d = latch_q;
					end else begin
						cnt_d = cnt_q - 8'd1;
					end
					if ((cnt_q != 8'd0 || reload_q) && cnt_d == 8'd0 && irq_en_q) begin
						irq_d = 1'b1;
					end
					reload_d = 1'b0;
					pend_d   = 1'b0;
				end
				// In cycle mode the prescaler raises a counter clock.
				if (cycle_mode_q) begin
					if (presc_dec == 3'd0) begin
						presc_d = CPU_PRESCALE;
						pend_d  = 1'b1;
					end else begin
						presc_d = presc_dec;
					end
				end
			end
			KIND_PPU_CYCLE: begin
				// A12 rises count only after the filter has run down.
				if (!cycle_mode_q) begin
					filt_d = filt_dec;
					if (filt_dec == 4'd0 && it.ppu_addr[12]) begin
						pend_d = 1'b1;
					end
					if (it.ppu_addr[12]) begin
						filt_d = A12_FILTER_CYCLES;
					end
				end
			end
			default: ;
		endcase
	end

	assign banks_d.command  = cmd_d;
	assign banks_d.prg_regs = prg_d;
	assign banks_d.chr_regs = chr_d;

	cbm_bank_lookup u_lookup (
		.banks    (banks_d),
		.cpu_addr (it.cpu_addr),
		.ppu_addr (it.ppu_addr),
		.prg_bank (prg_bank),
		.chr_bank (chr_bank)
	);

	// Mapper state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q        <= 8'd0;
			prg_q        <= {3{PRG_LAST_BANK}};
			for (int i = 0; i < 8; i++) begin
				chr_q[i] <= 8'(i);
			end
			mirror_q     <= 1'b0;
			irq_en_q     <= 1'b0;
			cnt_q        <= 8'd0;
			latch_q      <= 8'd0;
			cycle_mode_q <= 1'b0;
			reload_q     <= 1'b0;
			filt_q       <= 4'd0;
			pend_q       <= 1'b0;
			presc_q      <= CPU_PRESCALE;
			irq_q        <= 1'b0;
		end else if (accept) begin
			cmd_q        <= cmd_d;
			prg_q        <= prg_d;
			chr_q        <= chr_d;
			mirror_q     <= mirror_d;
			irq_en_q     <= irq_en_d;
			cnt_q        <= cnt_d;
			latch_q      <= latch_d;
			cycle_mode_q <= cycle_mode_d;
			reload_q     <= reload_d;
			filt_q       <= filt_d;
			pend_q       <= pend_d;
			presc_q      <= presc_d;
			irq_q        <= irq_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.prg_bank          <= prg_bank;
			out_q.chr_bank          <= chr_bank;
			out_q.mirror_horizontal <= mirror_d;
			out_q.irq               <= irq_d;
		end
	end

endmodule

[dv/tb_cartridge_bank_mapper_irq.sv]
// Testbench for the cartridge bank mapper: directed table, random bus traffic and a scoreboard.
`timescale 1ns / 100ps

module tb_cartridge_bank_mapper_irq;
	import cbm_pkg::*;

	// Item kind 3 is not a bus event; the block only reports its lookups.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// Address bits 15:13 of the IRQ enable and acknowledge registers.
	localparam logic [2:0] REGION_IRQ_ENABLE = 3'd7;

	localparam int N_DIRECTED   = 25;
	localparam int PHASE_ITEMS  = 500;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 5000;
	localparam int MAX_PRINTED  = 40;

	typedef struct {
		cbm_item_t   ev;
		bit          golden_valid;
		cbm_result_t golden;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;

	cbm_item_if   item_ch ();
	cbm_result_if result_ch ();

	cartridge_bank_mapper_irq dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Bus event table. A typed result is given only where it is obvious by eye.
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{'{KIND_UNUSED,    16'h0000, 8'h00, 14'h0000}, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b0}},
		'{'{KIND_UNUSED,    16'hFFFF, 8'hFF, 14'h3FFF}, 1'b1, '{8'hFF, 8'h00, 1'b0, 1'b0}},
		'{'{KIND_CPU_TICK,  16'h8000, 8'h00, 14'h1FFF}, 1'b1, '{8'hFF, 8'h07, 1'b0, 1'b0}},
		'{'{KIND_CPU_WRITE, 16'h7FFF, 8'hFF, 14'h0C00}, 1'b1, '{8'h00, 8'h03, 1'b0, 1'b0}},
		'{'{KIND_CPU_WRITE, 16'hA000, 8'h01, 14'h0400}, 1'b1, '{8'hFF, 8'h01, 1'b1, 1'b0}},
		'{'{KIND_CPU_WRITE, 16'hA001, 8'h00, 14'h2000}, 1'b1, '{8'hFF, 8'h00, 1'b1, 1'b0}},
		'{'{KIND_CPU_WRITE, 16'h8000, 8'h06, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'h8001, 8'h00, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'h8000, 8'h0F, 14'h0800}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'h8001, 8'h3F, 14'h1400}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'h8000, 8'h0A, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'h8001, 8'h55, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'h8000, 8'hE0, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'h9FFF, 8'hFF, 14'h1000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'h8000, 8'h08, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'h8001, 8'h81, 14'h0400}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'hC000, 8'h00, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'hC001, 8'h00, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'hE001, 8'h00, 14'h0000}, 1'b0, '0},
		'{'{KIND_PPU_CYCLE, 16'hC000, 8'h00, 14'h1000}, 1'b0, '0},
		'{'{KIND_CPU_TICK,  16'hA000, 8'h00, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'hE000, 8'h00, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'hC000, 8'hFF, 14'h0000}, 1'b0, '0},
		'{'{KIND_CPU_WRITE, 16'hC001, 8'h01, 14'h0000}, 1'b0, '0},
		'{'{KIND_PPU_CYCLE, 16'hFFFE, 8'h00, 14'h1FFF}, 1'b0, '0}
	};

	// Mapper state as the scoreboard sees it.
	logic [7:0] bank_select;
	logic [7:0] prg_bank_reg [3];
	logic [7:0] chr_bank_reg [8];
	logic       mirror_flag;
	logic       irq_armed;
	logic [7:0] scan_count;
	logic [7:0] scan_latch;
	logic       cpu_clocked_mode;
	logic       reload_pending;
	logic [3:0] a12_holdoff;
	logic       clock_due;
	logic [2:0] cpu_divider;
	logic       irq_out;

	cbm_result_t expected_results [$];

	int errors = 0;
	int results_checked = 0;
	int irq_results = 0;
	int items_sent = 0;
	int kind_count [4] = '{0, 0, 0, 0};
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit long_hold_req = 1'b0;

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Print one line per mismatch, up to a cap, and count every one.
	task automatic flag_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	// Apply one bus event to the mapper state and return the lookups that follow it.
	function automatic cbm_result_t mapper_step(input cbm_item_t ev);
		logic       odd;
		logic [7:0] prev;
		logic [1:0] prg_idx;
		logic [2:0] cslot;
		logic [2:0] j;
		cbm_result_t r;
		odd = ev.cpu_addr[0];
		case (ev.kind)
			KIND_CPU_WRITE: begin
				if (ev.cpu_addr[15]) begin
					case (ev.cpu_addr[15:13])
						REGION_BANK: begin
							if (!odd) begin
								bank_select = ev.write_data;
							end else begin
								case (bank_select[3:0])
									SEL_CHR0: chr_bank_reg[0] = ev.write_data;
									SEL_CHR2: chr_bank_reg[2] = ev.write_data;
									SEL_CHR4: chr_bank_reg[4] = ev.write_data;
									SEL_CHR5: chr_bank_reg[5] = ev.write_data;
									SEL_CHR6: chr_bank_reg[6] = ev.write_data;
									SEL_CHR7: chr_bank_reg[7] = ev.write_data;
									SEL_PRG0: prg_bank_reg[0] = ev.write_data;
									SEL_PRG1: prg_bank_reg[1] = ev.write_data;
									SEL_CHR1: chr_bank_reg[1] = ev.write_data;
									SEL_CHR3: chr_bank_reg[3] = ev.write_data;
									SEL_PRG2: prg_bank_reg[2] = ev.write_data;
									default: ;
								endcase
							end
						end
						REGION_MIRROR: begin
							if (!odd)
								mirror_flag = ev.write_data[0];
						end
						REGION_IRQ: begin
							if (odd) begin
								cpu_clocked_mode = ev.write_data[0];
								reload_pending = 1'b1;
							end else begin
								scan_latch = ev.write_data;
							end
						end
						default: begin
							irq_armed = odd;
							if (!odd)
								irq_out = 1'b0;
						end
					endcase
				end
			end
			KIND_CPU_TICK: begin
				// A pending counter clock lands on this tick.
				if (clock_due) begin
					prev = scan_count;
					if (prev == 8'd0 || reload_pending)
						scan_count = scan_latch;
					else
						scan_count = prev - 8'd1;
					if ((prev != 8'd0 || reload_pending) && scan_count == 8'd0 && irq_armed)
						irq_out = 1'b1;
					reload_pending = 1'b0;
					clock_due = 1'b0;
				end
				if (cpu_clocked_mode) begin
					cpu_divider = cpu_divider - 3'd1;
					if (cpu_divider == 3'd0) begin
						cpu_divider = CPU_PRESCALE;
						clock_due = 1'b1;
					end
				end
			end
			KIND_PPU_CYCLE: begin
				// A12 rises count only after the filter has run out.
				if (!cpu_clocked_mode) begin
					if (a12_holdoff != 4'd0)
						a12_holdoff = a12_holdoff - 4'd1;
					if (a12_holdoff == 4'd0 && ev.ppu_addr[12])
						clock_due = 1'b1;
					if (ev.ppu_addr[12])
						a12_holdoff = A12_FILTER_CYCLES;
				end
			end
			default: ;
		endcase

		// PRG lookup: slot 3 is fixed, swap mode rotates slots 0 to 2.
		prg_idx = ev.cpu_addr[14:13];
		if (bank_select[CMD_PRG_SWAP])
			prg_idx = (prg_idx == 2'd0) ? 2'd2 : prg_idx - 2'd1;
		if (!ev.cpu_addr[15])
			r.prg_bank = 8'h00;
		else if (ev.cpu_addr[14:13] == 2'd3)
			r.prg_bank = PRG_LAST_BANK;
		else
			r.prg_bank = prg_bank_reg[prg_idx];

		// CHR lookup: inversion swaps the halves, 2K mode pairs the low slots.
		cslot = ev.ppu_addr[12:10];
		j = cslot ^ {bank_select[CMD_CHR_INVERT], 2'b00};
		if (ev.ppu_addr[13])
			r.chr_bank = 8'h00;
		else if (bank_select[CMD_CHR_1K] || j[2])
			r.chr_bank = chr_bank_reg[j];
		else
			r.chr_bank = {chr_bank_reg[{1'b0, j[1], 1'b0}][7:1], cslot[0]};

		r.mirror_horizontal = mirror_flag;
		r.irq = irq_out;
		return r;
	endfunction

	// Offer one bus event, wait for its transaction, then record what should come back.
	task automatic offer_event(input cbm_item_t ev, input bit golden_valid = 1'b0,
			input cbm_result_t golden = '0);
		cbm_result_t predicted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= ev;
		do
			@(posedge clk);
		while (!item_ch.ready);
		predicted = mapper_step(ev);
		expected_results.push_back(golden_valid ? golden : predicted);
		items_sent++;
		kind_count[ev.kind]++;
	endtask

	// Register write address with random don't-care bits.
	function automatic logic [15:0] reg_addr(input logic [2:0] region, input logic odd);
		return {region, 12'($urandom), odd};
	endfunction

	// PPU address with A12 forced to the given level.
	function automatic logic [13:0] ppu_at(input logic a12);
		logic [13:0] a;
		a = 14'($urandom);
		a[12] = a12;
		return a;
	endfunction

	// Stop offering and wait until every outstanding result has come back.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random ready, with one long hold-off on request.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Scoreboard: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		cbm_result_t got;
		cbm_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_results.size() == 0) begin
				flag_error("result transaction with nothing expected");
			end else begin
				want = expected_results.pop_front();
				if (got.prg_bank !== want.prg_bank)
					flag_error($sformatf("result %0d prg_bank %02h, expected %02h",
						results_checked, got.prg_bank, want.prg_bank));
				if (got.chr_bank !== want.chr_bank)
					flag_error($sformatf("result %0d chr_bank %02h, expected %02h",
						results_checked, got.chr_bank, want.chr_bank));
				if (got.mirror_horizontal !== want.mirror_horizontal)
					flag_error($sformatf("result %0d mirror_horizontal %b, expected %b",
						results_checked, got.mirror_horizontal, want.mirror_horizontal));
				if (got.irq !== want.irq)
					flag_error($sformatf("result %0d irq %b, expected %b",
						results_checked, got.irq, want.irq));
			end
			if (got.irq === 1'b1)
				irq_results++;
			results_checked++;
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		int quiet_cycles;
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Stimulus.
	initial begin
		int tx_pct [3];
		int rx_pct [3];
		int n;
		logic [7:0] d;
		bit hold_done;
		tx_pct = '{18, 77, 0};
		rx_pct = '{77, 18, 0};
		hold_done = 1'b0;

		// Reset state of the scoreboard's copy of the mapper.
		bank_select = 8'h00;
		foreach (prg_bank_reg[i])
			prg_bank_reg[i] = 8'hFF;
		foreach (chr_bank_reg[i])
			chr_bank_reg[i] = 8'(i);
		mirror_flag = 1'b0;
		irq_armed = 1'b0;
		scan_count = 8'h00;
		scan_latch = 8'h00;
		cpu_clocked_mode = 1'b0;
		reload_pending = 1'b0;
		a12_holdoff = 4'd0;
		clock_due = 1'b0;
		cpu_divider = CPU_PRESCALE;
		irq_out = 1'b0;

		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (directed_rows[i])
			offer_event(directed_rows[i].ev, directed_rows[i].golden_valid,
				directed_rows[i].golden);
		drain_results();

		// Random traffic in three idling phases, draining between them.
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = tx_pct[phase];
			rx_idle_pct = rx_pct[phase];
			n = items_sent + PHASE_ITEMS;
			while (items_sent < n) begin
				// Long result-side hold-off halfway through the last phase.
				if (phase == 2 && !hold_done && items_sent > n - PHASE_ITEMS / 2) begin
					long_hold_req = 1'b1;
					hold_done = 1'b1;
				end
				case ($urandom_range(0, 9))
					0, 1: begin
						// Bank select followed by its data byte.
						d = 8'($urandom);
						offer_event(cbm_item_t'{KIND_CPU_WRITE, reg_addr(REGION_BANK, 1'b0), d,
							14'($urandom)});
						offer_event(cbm_item_t'{KIND_CPU_WRITE, reg_addr(REGION_BANK, 1'b1),
							8'($urandom), 14'($urandom)});
					end
					2: begin
						offer_event(cbm_item_t'{KIND_CPU_WRITE,
							reg_addr(REGION_MIRROR, 1'($urandom)), 8'($urandom), 14'($urandom)});
					end
					3: begin
						// IRQ setup: latch mostly small, reload with a mode, then mostly enable.
						d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
						offer_event(cbm_item_t'{KIND_CPU_WRITE, reg_addr(REGION_IRQ, 1'b0), d,
							14'($urandom)});
						d = 8'($urandom);
						d[0] = ($urandom_range(0, 3) == 0);
						offer_event(cbm_item_t'{KIND_CPU_WRITE, reg_addr(REGION_IRQ, 1'b1), d,
							14'($urandom)});
						offer_event(cbm_item_t'{KIND_CPU_WRITE,
							reg_addr(REGION_IRQ_ENABLE, 1'($urandom_range(0, 3) != 0)),
							8'($urandom), 14'($urandom)});
					end
					4, 5: begin
						// One scanline: A12 low, not always long enough to clear the filter, then high.
						repeat ($urandom_range(0, 12))
							offer_event(cbm_item_t'{KIND_PPU_CYCLE, 16'($urandom), 8'($urandom),
								ppu_at(1'b0)});
						repeat ($urandom_range(1, 3))
							offer_event(cbm_item_t'{KIND_PPU_CYCLE, 16'($urandom), 8'($urandom),
								ppu_at(1'b1)});
						offer_event(cbm_item_t'{KIND_CPU_TICK, 16'($urandom), 8'($urandom),
							14'($urandom)});
					end
					6, 7: begin
						repeat ($urandom_range(1, 8))
							offer_event(cbm_item_t'{KIND_CPU_TICK, 16'($urandom), 8'($urandom),
								14'($urandom)});
					end
					8: begin
						// Noise: any kind, any address, any data.
						offer_event(cbm_item_t'{2'($urandom), 16'($urandom), 8'($urandom),
							14'($urandom)});
					end
					default: begin
						repeat ($urandom_range(1, 6))
							offer_event(cbm_item_t'{
								$urandom_range(0, 1) ? KIND_CPU_TICK : KIND_PPU_CYCLE,
								16'($urandom), 8'($urandom), 14'($urandom)});
					end
				endcase
			end
			drain_results();
		end

		// Let any stray result show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_results.size()));

		$display("Run covered %0d bus events: %0d writes, %0d CPU ticks, %0d PPU cycles, %0d other.",
			items_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		$display("Checked %0d results, %0d with IRQ asserted; %0d mismatches.",
			results_checked, irq_results, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
